// ===== sv/assert_macros.svh =====
// Assertion macros used by the top level of the transcoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/u16u8_pkg.sv =====
// Shared types, constants and byte-encoding functions of the UTF-16 to UTF-8 transcoder.
package u16u8_pkg;

    localparam int CNT_W = 12;
    localparam int CP_W  = 21;

    // Top six bits of surrogate code units
    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

    // Offset of the high-surrogate bits that yields plane 1 and up
    localparam logic [10:0] PLANE_OFFSET = 11'd64;

    // UTF-8 byte prefixes
    localparam logic [0:0] PFX_ASCII = 1'b0;
    localparam logic [1:0] PFX_CONT  = 2'b10;
    localparam logic [2:0] PFX_LEAD2 = 3'b110;
    localparam logic [3:0] PFX_LEAD3 = 4'b1110;
    localparam logic [4:0] PFX_LEAD4 = 5'b11110;

    // Sequence length minus one
    localparam logic [1:0] LEN_1 = 2'd0;
    localparam logic [1:0] LEN_2 = 2'd1;
    localparam logic [1:0] LEN_3 = 2'd2;
    localparam logic [1:0] LEN_4 = 2'd3;

    typedef struct packed {
        logic            vld;
        logic [CP_W-1:0] cp;
        logic [1:0]      len_m1;
    } char_t;

    // One request from the front: up to two characters and an optional status item
    typedef struct packed {
        char_t            a;
        char_t            b;
        logic             eos;
        logic [CNT_W-1:0] count;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [1:0] {
        PART_A,
        PART_B,
        PART_S
    } part_t;

    function automatic logic [1:0] char_len_m1(input logic [CP_W-1:0] cp);
        logic [1:0] l;
        if (cp[CP_W-1:7] == '0)
            l = LEN_1;
        else if (cp[CP_W-1:11] == '0)
            l = LEN_2;
        else if (cp[CP_W-1:16] == '0)
            l = LEN_3;
        else
            l = LEN_4;
        return l;
    endfunction

    function automatic logic [7:0] utf8_byte(input char_t ch, input logic [1:0] idx);
        logic [7:0] b;
        unique case (ch.len_m1)
            LEN_1: b = {PFX_ASCII, ch.cp[6:0]};
            LEN_2: b = (idx == 2'd0) ? {PFX_LEAD2, ch.cp[10:6]} : {PFX_CONT, ch.cp[5:0]};
            LEN_3:
            begin
                case (idx)
                    2'd0:    b = {PFX_LEAD3, ch.cp[15:12]};
                    2'd1:    b = {PFX_CONT, ch.cp[11:6]};
                    default: b = {PFX_CONT, ch.cp[5:0]};
                endcase
            end
            default:
            begin
                case (idx)
                    2'd0:    b = {PFX_LEAD4, ch.cp[20:18]};
                    2'd1:    b = {PFX_CONT, ch.cp[17:12]};
                    2'd2:    b = {PFX_CONT, ch.cp[11:6]};
                    default: b = {PFX_CONT, ch.cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// ===== sv/u16u8_front.sv =====
// Front end: accepts code units, pairs surrogates, applies the byte capacity, queues requests.
module u16u8_front
    import u16u8_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [15:0]      code_unit,
    input  logic             last_unit,
    input  logic [CNT_W-1:0] max_bytes,
    input  q_stat_t          q_stat,
    output logic             push,
    output entry_t           push_entry
);

    logic             held_v_reg, held_v_next;
    logic [9:0]       held_bits_reg, held_bits_next;
    logic [CNT_W-1:0] bw_reg, bw_next;
    logic             stopped_reg, stopped_next;

    logic             acc, is_high, is_low, pair;
    logic             a_req, b_req, a_fit, b_fit, a_out, b_out, stop1, stop2;
    logic [CP_W-1:0]  a_cp, b_cp;
    logic [1:0]       a_len, b_len;
    logic [CNT_W:0]   sum_a, sum_b;
    logic [CNT_W-1:0] bw1, bw2;

    assign in_stall = q_stat.full;
    assign acc      = in_valid && !q_stat.full;
    assign is_high  = (code_unit[15:10] == HIGH_SURR_TAG);
    assign is_low   = (code_unit[15:10] == LOW_SURR_TAG);
    assign pair     = held_v_reg && is_low;

    // Classify: the held surrogate (alone or paired) first, then the current unit
    always_comb
    begin
        a_req = held_v_reg;
        if (pair)
            a_cp = {held_bits_reg + PLANE_OFFSET, code_unit[9:0]};
        else
            a_cp = {5'd0, HIGH_SURR_TAG, held_bits_reg};
        b_req = !pair && !(is_high && !last_unit);
        b_cp  = {5'd0, code_unit};
        a_len = char_len_m1(a_cp);
        b_len = char_len_m1(b_cp);
    end

    // Check each character against the remaining capacity in order
    always_comb
    begin
        sum_a = {1'b0, bw_reg} + {{(CNT_W-1){1'b0}}, a_len} + 13'd1;
        a_fit = sum_a <= {1'b0, max_bytes};
        a_out = a_req && !stopped_reg && a_fit;
        stop1 = stopped_reg || (a_req && !a_fit);
        bw1   = a_out ? sum_a[CNT_W-1:0] : bw_reg;

        sum_b = {1'b0, bw1} + {{(CNT_W-1){1'b0}}, b_len} + 13'd1;
        b_fit = sum_b <= {1'b0, max_bytes};
        b_out = b_req && !stop1 && b_fit;
        stop2 = stop1 || (b_req && !b_fit);
        bw2   = b_out ? sum_b[CNT_W-1:0] : bw1;
    end

    // Build the request; drop it when the unit gives no result
    always_comb
    begin
        push_entry.a     = '{vld: a_out, cp: a_cp, len_m1: a_len};
        push_entry.b     = '{vld: b_out, cp: b_cp, len_m1: b_len};
        push_entry.eos   = last_unit;
        push_entry.count = bw2;
        push             = acc && (a_out || b_out || last_unit);
    end

    // Advance the string state; clear it at the end of a string
    always_comb
    begin
        held_v_next    = held_v_reg;
        held_bits_next = held_bits_reg;
        bw_next        = bw_reg;
        stopped_next   = stopped_reg;
        if (acc)
        begin
            if (last_unit)
            begin
                held_v_next    = 1'b0;
                held_bits_next = '0;
                bw_next        = '0;
                stopped_next   = 1'b0;
            end
            else
            begin
                held_v_next    = is_high;
                held_bits_next = is_high ? code_unit[9:0] : held_bits_reg;
                bw_next        = bw2;
                stopped_next   = stop2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_v_reg    <= 1'b0;
            held_bits_reg <= '0;
            bw_reg        <= '0;
            stopped_reg   <= 1'b0;
        end
        else
        begin
            held_v_reg    <= held_v_next;
            held_bits_reg <= held_bits_next;
            bw_reg        <= bw_next;
            stopped_reg   <= stopped_next;
        end
    end

endmodule

// ===== sv/u16u8_queue.sv =====
// Request queue between the front end and the byte emitter.
module u16u8_queue
    import u16u8_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  entry_t  push_entry,
    input  logic    pop,
    output entry_t  head,
    output q_stat_t q_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

    entry_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign q_stat.full  = (cnt_reg == FULL_CNT);
    assign q_stat.empty = (cnt_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the request payload
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== sv/u16u8_back.sv =====
// Back end: walks queued requests, emitting one UTF-8 byte or status item per unstalled cycle.
module u16u8_back
    import u16u8_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  entry_t           head,
    input  q_stat_t          q_stat,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             byte_valid,
    output logic [CNT_W-1:0] byte_count,
    output logic             end_of_string,
    output logic             last_of_run
);

    part_t            sel_reg, sel_next;
    logic [1:0]       idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       byte_reg;
    logic             bvalid_reg;
    logic [CNT_W-1:0] count_reg;
    logic             eos_reg;
    logic             last_reg;

    part_t            cur;
    char_t            ch;
    logic             load, last_byte, final_res;

    // Pick the part to emit: skip characters that were dropped
    always_comb
    begin
        if (sel_reg == PART_A && head.a.vld)
            cur = PART_A;
        else if (sel_reg != PART_S && head.b.vld)
            cur = PART_B;
        else
            cur = PART_S;
        ch        = (cur == PART_A) ? head.a : head.b;
        last_byte = (idx_reg == ch.len_m1);
        load      = !q_stat.empty && (!out_valid_reg || !out_stall);
    end

    // Next position within the request, and whether this is its final result
    always_comb
    begin
        sel_next  = sel_reg;
        idx_next  = idx_reg;
        final_res = 1'b1;
        unique case (cur)
            PART_A:  final_res = last_byte && !head.b.vld && !head.eos;
            PART_B:  final_res = last_byte && !head.eos;
            default: final_res = 1'b1;
        endcase
        if (load)
        begin
            if (final_res)
            begin
                sel_next = PART_A;
                idx_next = '0;
            end
            else if (!last_byte)
                idx_next = idx_reg + 1'b1;
            else
            begin
                sel_next = (cur == PART_A) ? PART_B : PART_S;
                idx_next = '0;
            end
        end
        pop = load && final_res;
    end

    // Hold the output while stalled, drop it once taken
    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= PART_A;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg       <= sel_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (cur == PART_S)
            begin
                byte_reg   <= '0;
                bvalid_reg <= 1'b0;
                count_reg  <= head.count;
                eos_reg    <= 1'b1;
            end
            else
            begin
                byte_reg   <= utf8_byte(ch, idx_reg);
                bvalid_reg <= 1'b1;
                count_reg  <= '0;
                eos_reg    <= 1'b0;
            end
            last_reg <= final_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = byte_reg;
    assign byte_valid    = bvalid_reg;
    assign byte_count    = count_reg;
    assign end_of_string = eos_reg;
    assign last_of_run   = last_reg;

endmodule

// ===== sv/utf16_to_utf8_transcoder.sv =====
// Top level of the UTF-16 to UTF-8 transcoder: front end, request queue, byte emitter.
// The first result of a code unit passes the request queue, then the emitter's output register.
// The byte emitter gives one result per cycle while out_stall is low; a unit with several results
// holds it until the last is loaded. Units are accepted every cycle while the queue has room.
// Reset clears the string state, empties the queue and sets max_bytes to 1024; no clearing pass.
`include "assert_macros.svh"

module utf16_to_utf8_transcoder
    import u16u8_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [15:0]      code_unit,
    input  logic             last_unit,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             byte_valid,
    output logic [CNT_W-1:0] byte_count,
    output logic             end_of_string,
    output logic             last_of_run
);

    localparam logic [CNT_W-1:0] MAX_BYTES_RST = 12'd1024;

    logic [CNT_W-1:0] max_bytes_reg;
    q_stat_t          q_stat;
    logic             push, pop;
    entry_t           push_entry, head;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_bytes_reg <= MAX_BYTES_RST;
        else if (cfg_wr_en)
            max_bytes_reg <= cfg_wr_data;
    end

    u16u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .code_unit  (code_unit),
        .last_unit  (last_unit),
        .max_bytes  (max_bytes_reg),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    u16u8_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_stat        (q_stat),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .byte_count    (byte_count),
        .end_of_string (end_of_string),
        .last_of_run   (last_of_run)
    );

    `ASSERT_IMPL(a_status_shape, clk, rst_n, out_valid && end_of_string,
        !byte_valid && last_of_run && out_byte == 8'd0, "status item malformed")
    `ASSERT_IMPL(a_byte_shape, clk, rst_n, out_valid && byte_valid,
        !end_of_string && byte_count == '0, "byte item carries status fields")
    `ASSERT_IMPL(a_count_cap, clk, rst_n, out_valid && end_of_string,
        byte_count <= max_bytes_reg, "byte count exceeds capacity")
    `ASSERT_CLK(a_no_pop_empty, clk, rst_n, !(pop && q_stat.empty), "pop from empty queue")

endmodule
